### rtl/core/tkut_pkg.sv
// shared widths, defaults and the result record for the top-k threshold tracker
// no dependencies
package tkut_pkg;

  localparam int TAG_W        = 32;
  localparam int UTIL_W       = 31;
  localparam int CNT_W        = 5;
  localparam int MAX_KEPT_DEF = 16;
  localparam logic [CNT_W-1:0] K_RESET = CNT_W'(16);

  typedef struct packed {
    logic [UTIL_W-1:0] threshold;
    logic [CNT_W-1:0]  held_count;
    logic              kept;
  } result_t;

endpackage

### rtl/core/tkut_kctl.sv
// k_in_use register, with zero read as one and clamping to the usable store depth
// depends on tkut_pkg
module tkut_kctl #(
  parameter int MAX_KEPT = tkut_pkg::MAX_KEPT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      wr_en,
  input  logic [tkut_pkg::CNT_W-1:0] wr_data,
  output logic [tkut_pkg::CNT_W-1:0] k_eff
);
  import tkut_pkg::*;

  localparam int KCAP = (MAX_KEPT > (2**CNT_W - 1)) ? (2**CNT_W - 1) : MAX_KEPT;
  localparam logic [CNT_W-1:0] KMAX = CNT_W'(KCAP);

  logic [CNT_W-1:0] k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= K_RESET;
    end else if (wr_en) begin
      k_r <= wr_data;
    end
  end

  always_comb begin
    if (k_r == '0) begin
      k_eff = CNT_W'(1);
    end else if (k_r > KMAX) begin
      k_eff = KMAX;
    end else begin
      k_eff = k_r;
    end
  end

endmodule

### rtl/core/tkut_store.sv
// sorted candidate store with parallel compare and shift insert
// depends on tkut_pkg
module tkut_store #(
  parameter int MAX_KEPT = tkut_pkg::MAX_KEPT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       upd,
  input  logic [tkut_pkg::TAG_W-1:0]  cand_tag,
  input  logic [tkut_pkg::UTIL_W-1:0] cand_util,
  input  logic [tkut_pkg::CNT_W-1:0]  k_eff,
  output logic [tkut_pkg::CNT_W-1:0]  held_cur,
  output tkut_pkg::result_t           res
);
  import tkut_pkg::*;

  logic [UTIL_W-1:0] util_r   [MAX_KEPT];
  logic [TAG_W-1:0]  tag_r    [MAX_KEPT];
  logic [UTIL_W-1:0] util_nxt [MAX_KEPT];
  logic [TAG_W-1:0]  tag_nxt  [MAX_KEPT];
  logic [CNT_W-1:0]  held_r;
  logic [CNT_W-1:0]  held_nxt;
  logic [MAX_KEPT:0] le;
  logic              full;
  logic              do_ins;
  logic              do_rep;

  assign full   = held_r >= k_eff;
  assign do_ins = !full;
  assign do_rep = full && (cand_util > util_r[0]);

  genvar j;
  generate
    for (j = 0; j < MAX_KEPT; j++) begin : g_cmp
      assign le[j] = (CNT_W'(j) < held_r) && (j < 2**CNT_W) && (util_r[j] <= cand_util);
    end
  endgenerate
  assign le[MAX_KEPT] = 1'b0;

  generate
    for (j = 0; j < MAX_KEPT; j++) begin : g_upd
      if (j == 0) begin : g_first
        always_comb begin
          if (do_rep) begin
            if (le[1]) begin
              util_nxt[0] = (MAX_KEPT > 1) ? util_r[(MAX_KEPT > 1) ? 1 : 0] : cand_util;
              tag_nxt[0]  = (MAX_KEPT > 1) ? tag_r[(MAX_KEPT > 1) ? 1 : 0] : cand_tag;
            end else begin
              util_nxt[0] = cand_util;
              tag_nxt[0]  = cand_tag;
            end
          end else if (le[0]) begin
            util_nxt[0] = util_r[0];
            tag_nxt[0]  = tag_r[0];
          end else begin
            util_nxt[0] = cand_util;
            tag_nxt[0]  = cand_tag;
          end
        end
      end else begin : g_rest
        always_comb begin
          if (do_rep) begin
            if (le[j+1]) begin
              util_nxt[j] = util_r[(j+1 < MAX_KEPT) ? j+1 : j];
              tag_nxt[j]  = tag_r[(j+1 < MAX_KEPT) ? j+1 : j];
            end else if (le[j]) begin
              util_nxt[j] = cand_util;
              tag_nxt[j]  = cand_tag;
            end else begin
              util_nxt[j] = util_r[j];
              tag_nxt[j]  = tag_r[j];
            end
          end else if (le[j]) begin
            util_nxt[j] = util_r[j];
            tag_nxt[j]  = tag_r[j];
          end else if (le[j-1]) begin
            util_nxt[j] = cand_util;
            tag_nxt[j]  = cand_tag;
          end else begin
            util_nxt[j] = util_r[j-1];
            tag_nxt[j]  = tag_r[j-1];
          end
        end
      end

      always_ff @(posedge clk) begin
        if (upd && (do_ins || do_rep)) begin
          util_r[j] <= util_nxt[j];
          tag_r[j]  <= tag_nxt[j];
        end
      end
    end
  endgenerate

  assign held_nxt = do_ins ? held_r + CNT_W'(1) : held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else if (upd) begin
      held_r <= held_nxt;
    end
  end

  assign held_cur       = held_r;
  assign res.threshold  = (do_ins || do_rep) ? util_nxt[0] : util_r[0];
  assign res.held_count = held_nxt;
  assign res.kept       = do_ins || do_rep;

endmodule

### rtl/core/top_k_utility_threshold_top.sv
// top level of the top-k utility threshold tracker: input register, store, result register
// depends on tkut_pkg, tkut_kctl and tkut_store
//
// Each candidate waits in the input register, where it is compared in parallel
// against every held entry and shift-inserted into the sorted store, and the result is
// captured into the result register on the edge that updates the store. One candidate
// is accepted every clock while results are taken; a result held back by out_ready
// stalls the input register and so the input. The user must write k_in_use through
// the cfg port only while no candidate is in flight; the block itself does not enforce it.
// Zero acts as one and values above the store depth act as the depth. The store needs
// no clearing after reset.
module top_k_utility_threshold_top #(
  parameter int MAX_KEPT = tkut_pkg::MAX_KEPT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tkut_pkg::TAG_W-1:0]  in_itemset_tag,
  input  logic [tkut_pkg::UTIL_W-1:0] in_utility,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [tkut_pkg::UTIL_W-1:0] out_threshold,
  output logic [tkut_pkg::CNT_W-1:0]  out_held_count,
  output logic                       out_kept,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tkut_pkg::CNT_W-1:0]  cfg_data
);
  import tkut_pkg::*;

  logic              in_vld_r;
  logic [TAG_W-1:0]  in_tag_r;
  logic [UTIL_W-1:0] in_util_r;
  logic              out_vld_r;
  result_t           out_r;
  result_t           res;
  logic              fire;
  logic [CNT_W-1:0]  k_eff;
  logic [CNT_W-1:0]  held_cur;

  assign fire      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || fire;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_tag_r  <= in_itemset_tag;
      in_util_r <= in_utility;
    end
  end

  tkut_kctl #(.MAX_KEPT(MAX_KEPT)) u_kctl (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_data (cfg_data),
    .k_eff   (k_eff)
  );

  tkut_store #(.MAX_KEPT(MAX_KEPT)) u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (fire),
    .cand_tag  (in_tag_r),
    .cand_util (in_util_r),
    .k_eff     (k_eff),
    .held_cur  (held_cur),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_threshold  = out_r.threshold;
  assign out_held_count = out_r.held_count;
  assign out_kept       = out_r.kept;

  // a dropped candidate leaves the count alone
  a_drop_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !res.kept |-> res.held_count == held_cur)
    else $error("count changed on dropped candidate");

  // store never grows past the effective k by an insert
  a_insert_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.held_count != held_cur |-> res.held_count <= k_eff)
    else $error("insert beyond k");

  a_held_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_held_count != '0)
    else $error("result with empty store");

  a_ready_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with free result register");

endmodule

### tb/tkut_threshold_checker.sv
// checker for the top-k utility threshold tracker: follows k_in_use writes and candidate beats,
// keeps its own sorted store and compares every result beat against the oldest prediction
// depends on tkut_pkg
module tkut_threshold_checker #(
  parameter int MAX_KEPT = tkut_pkg::MAX_KEPT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [tkut_pkg::TAG_W-1:0]  in_itemset_tag,
  input  logic [tkut_pkg::UTIL_W-1:0] in_utility,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [tkut_pkg::UTIL_W-1:0] out_threshold,
  input  logic [tkut_pkg::CNT_W-1:0]  out_held_count,
  input  logic                        out_kept,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [tkut_pkg::CNT_W-1:0]  cfg_data,
  output int                          open_count,
  output int                          fail_count
);
  import tkut_pkg::*;

  logic [UTIL_W-1:0] kept_util [MAX_KEPT];
  logic [TAG_W-1:0]  kept_tag  [MAX_KEPT];
  int                kept_n;
  logic [CNT_W-1:0]  k_reg;
  result_t           threshold_q [$];

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("mismatch: %s", msg);
  endtask

  function automatic void place_sorted(input int count, input logic [TAG_W-1:0] tag,
                                       input logic [UTIL_W-1:0] util);
    int pos;
    pos = count;
    while (pos > 0 && kept_util[pos-1] > util) begin
      kept_util[pos] = kept_util[pos-1];
      kept_tag[pos]  = kept_tag[pos-1];
      pos--;
    end
    kept_util[pos] = util;
    kept_tag[pos]  = tag;
  endfunction

  function automatic result_t admit_candidate(input logic [TAG_W-1:0] tag,
                                              input logic [UTIL_W-1:0] util);
    int      k_eff;
    int      n;
    result_t r;
    k_eff = (k_reg == '0) ? 1 : ((int'(k_reg) > MAX_KEPT) ? MAX_KEPT : int'(k_reg));
    n = (kept_n > MAX_KEPT) ? MAX_KEPT : kept_n;
    r.kept = 1'b1;
    if (n < k_eff) begin
      place_sorted(n, tag, util);
      n++;
    end else if (util > kept_util[0]) begin
      // smallest entry leaves, the newcomer goes into the rest
      for (int i = 0; i < n - 1; i++) begin
        kept_util[i] = kept_util[i+1];
        kept_tag[i]  = kept_tag[i+1];
      end
      place_sorted(n - 1, tag, util);
    end else begin
      r.kept = 1'b0;
    end
    kept_n       = n;
    r.threshold  = kept_util[0];
    r.held_count = CNT_W'(n);
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      kept_n = 0;
      k_reg  = K_RESET;
      threshold_q.delete();
      fail_count = 0;
      open_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (threshold_q.size() == 0) begin
          report_mismatch($sformatf("result beat with nothing pending, threshold %0d",
                                    out_threshold));
        end else begin
          want = threshold_q.pop_front();
          if (out_threshold !== want.threshold)
            report_mismatch($sformatf("threshold %0d, predicted %0d",
                                      out_threshold, want.threshold));
          if (out_held_count !== want.held_count)
            report_mismatch($sformatf("held_count %0d, predicted %0d",
                                      out_held_count, want.held_count));
          if (out_kept !== want.kept)
            report_mismatch($sformatf("kept %0b, predicted %0b", out_kept, want.kept));
        end
      end
      if (cfg_valid && cfg_ready) k_reg = cfg_data;
      if (in_valid && in_ready)
        threshold_q.insert(threshold_q.size(), admit_candidate(in_itemset_tag, in_utility));
      open_count <= threshold_q.size();
    end
  end

endmodule

### tb/tb_top_k_utility_threshold_top.sv
// testbench top for top_k_utility_threshold_top: clock, reset, candidate and k_in_use stimulus,
// random stalls on both channels, watchdog and verdict
// depends on tkut_pkg, top_k_utility_threshold_top and tkut_threshold_checker
module tb_top_k_utility_threshold_top;
  import tkut_pkg::*;

  localparam int                ITEMS       = 1850;
  localparam int                PHASES      = 10;
  localparam int                IDLE_LIMIT  = 2000;
  localparam int                HOLD_CYCLES = 80;
  localparam int                SETTLE      = 10;
  localparam logic [UTIL_W-1:0] UTIL_MAX    = '1;
  localparam logic [CNT_W-1:0]  K_PLAN [6]  = '{5'd8, 5'd12, 5'd0, 5'd16, 5'd31, 5'd1};

  logic              clk;
  logic              rst_n          = 1'b0;
  logic              in_valid       = 1'b0;
  logic              in_ready;
  logic [TAG_W-1:0]  in_itemset_tag = '0;
  logic [UTIL_W-1:0] in_utility     = '0;
  logic              out_valid;
  logic              out_ready      = 1'b0;
  logic [UTIL_W-1:0] out_threshold;
  logic [CNT_W-1:0]  out_held_count;
  logic              out_kept;
  logic              cfg_valid      = 1'b0;
  logic              cfg_ready;
  logic [CNT_W-1:0]  cfg_data       = '0;

  int                open_count;
  int                fails;
  logic              calm           = 1'b0;
  int                hold_asked     = 0;
  int                hold_served    = 0;
  int                hold_left      = 0;
  int                ready_left     = 0;
  logic [UTIL_W-1:0] floor_seen     = '0;

  top_k_utility_threshold_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_itemset_tag (in_itemset_tag),
    .in_utility     (in_utility),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_threshold  (out_threshold),
    .out_held_count (out_held_count),
    .out_kept       (out_kept),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  tkut_threshold_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_itemset_tag (in_itemset_tag),
    .in_utility     (in_utility),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_threshold  (out_threshold),
    .out_held_count (out_held_count),
    .out_kept       (out_kept),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .open_count     (open_count),
    .fail_count     (fails)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // result side: random ready bursts, one long hold on request, none once calm
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      out_ready   <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_asked;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else begin
      out_ready  <= ($urandom_range(0, 2) != 0);
      ready_left <= $urandom_range(1, 18);
    end
  end

  // latest threshold seen, used to aim candidates near the boundary
  always @(posedge clk) begin
    if (!rst_n) begin
      floor_seen <= '0;
    end else if (out_valid && out_ready) begin
      floor_seen <= out_threshold;
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("tb_top_k_utility_threshold_top NOT OK");
    $finish;
  end

  task automatic send_candidate(input logic [TAG_W-1:0] tag, input logic [UTIL_W-1:0] util);
    in_valid       <= 1'b1;
    in_itemset_tag <= tag;
    in_utility     <= util;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
  endtask

  task automatic write_k(input logic [CNT_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic maybe_pause(input int odds);
    if (!calm && odds != 0 && $urandom_range(1, 8) <= odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  function automatic logic [UTIL_W-1:0] pick_utility();
    logic [31:0] wide;
    int          roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      wide = $urandom() & 32'h7FFF_FFFF;
    end else if (roll < 25) begin
      // at or below the threshold
      if (floor_seen > 50) wide = floor_seen - $urandom_range(0, 50);
      else wide = $urandom_range(0, floor_seen);
    end else begin
      wide = floor_seen + $urandom_range(0, 40);
      if (wide > UTIL_MAX) wide = UTIL_MAX;
    end
    return wide[UTIL_W-1:0];
  endfunction

  initial begin
    logic [CNT_W-1:0] k_next;
    int               odds;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset k: store grows, ties at zero
    send_candidate(32'h0000_0000, '0);
    send_candidate(32'hFFFF_FFFF, UTIL_MAX);
    send_candidate(32'hA5A5_5A5A, '0);
    // k lowered below the count held
    write_k(5'd1);
    send_candidate(32'h0000_0001, 31'd0);
    send_candidate(32'h0000_0002, 31'd5);
    send_candidate(32'h0000_0003, 31'd3);
    send_candidate(32'h0000_0004, 31'd3);
    send_candidate(32'h0000_0005, 31'd2);
    // zero acts as one
    write_k(5'd0);
    send_candidate(32'h8000_0000, 31'd4);
    send_candidate(32'h7FFF_FFFF, UTIL_MAX);
    // growth with ties, then drops below and equal to the minimum
    write_k(5'd5);
    send_candidate(32'h0F0F_0F0F, 31'd6);
    send_candidate(32'hF0F0_F0F0, 31'd6);
    send_candidate(32'h3C3C_3C3C, 31'd1);
    send_candidate(32'hC3C3_C3C3, 31'd5);
    send_candidate(32'h5555_5555, 31'h4000_0000);
    send_candidate(32'hAAAA_AAAA, 31'd6);
    // above the store depth
    write_k(5'd31);
    send_candidate(32'h1234_5678, 31'h2AAA_AAAA);
    send_candidate(32'h8765_4321, 31'h5555_5555);
    send_candidate(32'hDEAD_0001, 31'd7);

    for (int p = 0; p < PHASES; p++) begin
      k_next = (p < 6) ? K_PLAN[p] : CNT_W'($urandom_range(0, 31));
      write_k(k_next);
      odds = (p % 3 == 0) ? 0 : $urandom_range(1, 4);
      if (p == PHASES - 1) calm <= 1'b1;
      for (int i = 0; i < ITEMS / PHASES; i++) begin
        if (p == 2 && i == 40) hold_asked <= hold_asked + 1;
        maybe_pause(odds);
        send_candidate($urandom(), pick_utility());
      end
    end
    drain_results();
    repeat (SETTLE) @(posedge clk);

    if (fails == 0) begin
      $display("tb_top_k_utility_threshold_top OK");
    end else begin
      $display("tb_top_k_utility_threshold_top NOT OK");
    end
    $finish;
  end

endmodule
